FILE: hw/rtl/sntp7seg_pkg.sv
// Shared types, constants and helper functions for the network-time seven-segment display block.
package sntp7seg_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int TAG_LEN     = 13;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    localparam logic [3:0] BLANK_DIGIT = 4'd10;
    localparam logic [3:0] COLON_POINT = 4'h4;

    localparam logic signed [12:0] MAX_HOUR   = 13'sd23;
    localparam logic signed [12:0] MAX_MINUTE = 13'sd59;

    typedef logic [3:0] t_tag_idx;
    localparam t_tag_idx TAG_LAST = 4'(TAG_LEN - 1);

    localparam logic [7:0] TAG_TEXT [TAG_LEN] = '{
        8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h4E, 8'h54,
        8'h50, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3A
    };

    localparam logic [6:0] FONT [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic step;
        logic commit;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_tick;
        logic in_eol;
        logic line_nonempty;
        logic walk_done;
        logic out_free;
    } t_status;

    // A character is taken as a signed byte less the code of zero.
    function automatic logic signed [8:0] char_value(input logic [7:0] b);
        return $signed({b[7], b}) - 9'sd48;
    endfunction

    function automatic logic signed [12:0] pair_value(input logic [7:0] hi,
                                                      input logic [7:0] lo);
        logic signed [8:0]  h9;
        logic signed [8:0]  l9;
        logic signed [12:0] h;
        logic signed [12:0] l;
        h9 = char_value(hi);
        l9 = char_value(lo);
        h  = {{4{h9[8]}}, h9};
        l  = {{4{l9[8]}}, l9};
        return (h <<< 3) + (h <<< 1) + l;
    endfunction

    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd50) begin
            t = 4'd5;
        end else if (v >= 6'd40) begin
            t = 4'd4;
        end else if (v >= 6'd30) begin
            t = 4'd3;
        end else if (v >= 6'd20) begin
            t = 4'd2;
        end else if (v >= 6'd10) begin
            t = 4'd1;
        end else begin
            t = 4'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] t;
        logic [5:0] r;
        t = {2'b00, tens_of(v)};
        r = v - 6'((t << 3) + (t << 1));
        return r[3:0];
    endfunction

    function automatic logic [6:0] seg_of(input logic [3:0] v);
        logic [6:0] s;
        if (v < BLANK_DIGIT) begin
            s = FONT[v];
        end else begin
            s = '0;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/sntp7seg_if.sv
// Valid/ready channel interfaces for the input words and the result words.
interface sntp7seg_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, action, rx_byte, input ready);
    modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface sntp7seg_out_if;
    logic       valid;
    logic       ready;
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       time_updated;
    logic       scan_valid;
    logic [3:0] digit_enable_n;
    logic [6:0] segments;
    logic       decimal_point;

    modport source (output valid, echo_valid, echo_byte, time_updated, scan_valid,
                    digit_enable_n, segments, decimal_point, input ready);
    modport sink   (input valid, echo_valid, echo_byte, time_updated, scan_valid,
                    digit_enable_n, segments, decimal_point, output ready);
endinterface

FILE: hw/rtl/sntp7seg_ctrl.sv
// Controller state machine: accepts words, sequences the line walk and result load.
module sntp7seg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sntp7seg_pkg::t_status i_st,
    output sntp7seg_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WALK = 4'b0010,
        S_CALC = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    // Only a line end with stored bytes needs the walk.
                    if (!i_st.in_tick && i_st.in_eol && i_st.line_nonempty) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_st.walk_done) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_in_ready)
        else $error("a second word was accepted while one is in flight");

    a_calc_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |=> (r_state == S_EMIT))
        else $error("time update was not followed by the result load");

endmodule

FILE: hw/rtl/sntp7seg_dp.sv
// Datapath: line memory, tag and time scanner, display registers and result register.
module sntp7seg_dp #(
    parameter int LINE_BYTES = 80
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sntp7seg_pkg::t_cmd    i_cmd,
    output sntp7seg_pkg::t_status o_st,
    input  logic                  i_action,
    input  logic [7:0]            i_rx_byte,
    sntp7seg_out_if.source        o_out
);

    localparam int LEN_W = $clog2(LINE_BYTES);
    localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(LINE_BYTES - 1);

    typedef enum logic [5:0] {
        P_TAG   = 6'b000001,
        P_COLON = 6'b000010,
        P_MIN1  = 6'b000100,
        P_MIN2  = 6'b001000,
        P_DONE  = 6'b010000,
        P_FAIL  = 6'b100000
    } t_phase;

    logic [7:0]       r_store [LINE_BYTES];
    logic [7:0]       r_q;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_rd_idx;
    logic             r_rd_pend;

    logic             r_action;
    logic [7:0]       r_byte;
    logic             r_updated;
    logic [3:0]       r_digit [sntp7seg_pkg::DIGIT_COUNT];
    logic [3:0]       r_point;
    logic [1:0]       r_scan;

    t_phase                 r_phase, n_phase;
    sntp7seg_pkg::t_tag_idx r_k, n_k;
    logic [1:0]             r_cnt, n_cnt;
    logic [7:0]             r_prev1, n_prev1;
    logic [7:0]             r_prev2, n_prev2;
    logic [7:0]             r_m1, n_m1;
    logic [7:0]             r_m2, n_m2;

    logic             r_out_valid;
    logic             r_echo_valid;
    logic [7:0]       r_echo_byte;
    logic             r_time_updated;
    logic             r_scan_valid;
    logic [3:0]       r_digit_enable_n;
    logic [6:0]       r_segments;
    logic             r_decimal_point;

    logic             in_eol;
    logic             store_en;
    logic             proc_stop;
    logic             issue;
    logic             match;
    logic             time_ok;
    logic signed [12:0] w_hour;
    logic signed [12:0] w_min;

    assign in_eol   = (i_rx_byte == sntp7seg_pkg::CHAR_LF) ||
                      (i_rx_byte == sntp7seg_pkg::CHAR_CR);
    assign store_en = !i_action && !in_eol && (r_len < LAST_IDX);

    assign o_st.in_tick       = i_action;
    assign o_st.in_eol        = in_eol;
    assign o_st.line_nonempty = (r_len != '0);
    assign o_st.out_free      = !r_out_valid || o_out.ready;

    // Scanner for the byte read in the previous cycle. A zero byte ends the line.
    always_comb begin
        n_phase   = r_phase;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_prev1   = r_prev1;
        n_prev2   = r_prev2;
        n_m1      = r_m1;
        n_m2      = r_m2;
        proc_stop = 1'b0;
        if (r_rd_pend) begin
            if (r_q == sntp7seg_pkg::CHAR_NUL) begin
                proc_stop = 1'b1;
            end else begin
                unique case (r_phase)
                    P_TAG: begin
                        if (r_q == sntp7seg_pkg::TAG_TEXT[r_k]) begin
                            if (r_k == sntp7seg_pkg::TAG_LAST) begin
                                n_phase = P_COLON;
                                n_cnt   = '0;
                            end else begin
                                n_k = r_k + 4'd1;
                            end
                        end else begin
                            // The plus sign occurs only at the head of the tag.
                            n_k = (r_q == sntp7seg_pkg::CHAR_PLUS) ? 4'd1 : 4'd0;
                        end
                    end
                    P_COLON: begin
                        if (r_q == sntp7seg_pkg::CHAR_COLON) begin
                            if (r_cnt == 2'd2) begin
                                n_phase = P_MIN1;
                                n_m1    = '0;
                                n_m2    = '0;
                            end else begin
                                n_phase   = P_FAIL;
                                proc_stop = 1'b1;
                            end
                        end else begin
                            n_prev2 = r_prev1;
                            n_prev1 = r_q;
                            if (r_cnt != 2'd2) begin
                                n_cnt = r_cnt + 2'd1;
                            end
                        end
                    end
                    P_MIN1: begin
                        n_m1    = r_q;
                        n_phase = P_MIN2;
                    end
                    P_MIN2: begin
                        n_m2      = r_q;
                        n_phase   = P_DONE;
                        proc_stop = 1'b1;
                    end
                    P_DONE, P_FAIL: begin
                        proc_stop = 1'b1;
                    end
                    default: begin
                        proc_stop = 1'b1;
                    end
                endcase
            end
        end
    end

    assign issue          = !proc_stop && (r_rd_idx < r_len);
    assign o_st.walk_done = proc_stop || (!r_rd_pend && (r_rd_idx >= r_len));

    assign w_hour  = sntp7seg_pkg::pair_value(r_prev2, r_prev1);
    assign w_min   = sntp7seg_pkg::pair_value(r_m1, r_m2);
    assign match   = (r_phase == P_MIN1) || (r_phase == P_MIN2) || (r_phase == P_DONE);
    assign time_ok = (w_hour >= 13'sd0) && (w_hour <= sntp7seg_pkg::MAX_HOUR) &&
                     (w_min >= 13'sd0) && (w_min <= sntp7seg_pkg::MAX_MINUTE);

    // Line memory: one write port for arriving bytes, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && store_en) begin
            r_store[r_len] <= i_rx_byte;
        end
        if (i_cmd.step) begin
            r_q <= r_store[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_phase     <= P_TAG;
            r_k         <= '0;
            r_cnt       <= '0;
            r_updated   <= 1'b0;
            r_point     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sntp7seg_pkg::DIGIT_COUNT; i++) begin
                r_digit[i] <= sntp7seg_pkg::BLANK_DIGIT;
            end
        end else begin
            if (i_cmd.capture) begin
                r_updated <= 1'b0;
                r_rd_idx  <= '0;
                r_rd_pend <= 1'b0;
                r_phase   <= P_TAG;
                r_k       <= '0;
                r_cnt     <= '0;
                if (store_en) begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
            if (i_cmd.step) begin
                r_rd_idx  <= r_rd_idx + LEN_W'(issue);
                r_rd_pend <= issue;
                r_phase   <= n_phase;
                r_k       <= n_k;
                r_cnt     <= n_cnt;
            end
            if (i_cmd.commit) begin
                r_len <= '0;
                if (match && time_ok) begin
                    r_digit[3] <= sntp7seg_pkg::tens_of(w_hour[5:0]);
                    r_digit[2] <= sntp7seg_pkg::ones_of(w_hour[5:0]);
                    r_digit[1] <= sntp7seg_pkg::tens_of(w_min[5:0]);
                    r_digit[0] <= sntp7seg_pkg::ones_of(w_min[5:0]);
                    r_point    <= sntp7seg_pkg::COLON_POINT;
                    r_updated  <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (r_action) begin
                    r_scan <= r_scan + 2'd1;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_byte   <= i_rx_byte;
        end
        if (i_cmd.step) begin
            r_prev1 <= n_prev1;
            r_prev2 <= n_prev2;
            r_m1    <= n_m1;
            r_m2    <= n_m2;
        end
        if (i_cmd.load_out) begin
            if (r_action) begin
                r_echo_valid     <= 1'b0;
                r_echo_byte      <= '0;
                r_time_updated   <= 1'b0;
                r_scan_valid     <= 1'b1;
                r_digit_enable_n <= ~(4'b0001 << r_scan);
                r_segments       <= sntp7seg_pkg::seg_of(r_digit[r_scan]);
                r_decimal_point  <= r_point[r_scan];
            end else begin
                r_echo_valid     <= 1'b1;
                r_echo_byte      <= r_byte;
                r_time_updated   <= r_updated;
                r_scan_valid     <= 1'b0;
                r_digit_enable_n <= 4'hF;
                r_segments       <= '0;
                r_decimal_point  <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.echo_valid     = r_echo_valid;
    assign o_out.echo_byte      = r_echo_byte;
    assign o_out.time_updated   = r_time_updated;
    assign o_out.scan_valid     = r_scan_valid;
    assign o_out.digit_enable_n = r_digit_enable_n;
    assign o_out.segments       = r_segments;
    assign o_out.decimal_point  = r_decimal_point;

    a_two_hour_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_MIN1) |-> (r_cnt == 2'd2))
        else $error("minute capture entered without two hour characters");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_len <= LAST_IDX))
        else $error("line length ran past the memory");

    a_scan_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.scan_valid) |->
            ($onehot(~o_out.digit_enable_n) && !o_out.echo_valid && !o_out.time_updated))
        else $error("scan word does not select exactly one digit");

    a_point_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_updated) |-> (r_point == sntp7seg_pkg::COLON_POINT))
        else $error("time update without the colon point");

endmodule

FILE: hw/rtl/sntp_time_line_to_seven_segment_core.sv
// A scan tick or an ordinary byte gives its result word from the output register; no new word
// is accepted until that result has been loaded, which waits while the output is held off.
// A line end walks the line memory one stored byte per cycle through its registered read port.
// Reset (synchronous, active low) empties the line, blanks all digits, clears the points
// and returns the scan to the rightmost digit; the line memory itself is not cleared.
module sntp_time_line_to_seven_segment_core #(
    parameter int LINE_BYTES = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sntp7seg_in_if.sink     i_in,
    sntp7seg_out_if.source  o_out
);

    sntp7seg_pkg::t_cmd    w_cmd;
    sntp7seg_pkg::t_status w_st;
    logic                  w_in_ready;

    assign i_in.ready = w_in_ready;

    sntp7seg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    sntp7seg_dp #(
        .LINE_BYTES (LINE_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_st      (w_st),
        .i_action  (i_in.action),
        .i_rx_byte (i_in.rx_byte),
        .o_out     (o_out)
    );

endmodule

FILE: bench/sntp_time_line_to_seven_segment_core_tb.sv
// Self-checking testbench for the network-time line parser and seven-segment scan core.
module sntp_time_line_to_seven_segment_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES       = 80;
    localparam int TAG_LENGTH       = 13;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int IDLE_PERCENT     = 26;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int MAX_HOUR         = 23;
    localparam int MAX_MINUTE       = 59;
    localparam int BLANK            = 10;

    localparam bit ACT_BYTE = 1'b0;
    localparam bit ACT_TICK = 1'b1;

    localparam logic [7:0] CHR_LF    = 8'd10;
    localparam logic [7:0] CHR_CR    = 8'd13;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [3:0] HOUR_MINUTE_POINT = 4'h4;

    localparam logic [7:0] TAG_TEXT [TAG_LENGTH] = '{
        8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h4E, 8'h54,
        8'h50, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3A
    };

    localparam logic [6:0] DIGIT_GLYPHS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       time_updated;
        logic       scan_valid;
        logic [3:0] digit_enable_n;
        logic [6:0] segments;
        logic       decimal_point;
    } t_display_word;

    logic i_clk;
    logic i_rst_n;

    sntp7seg_in_if  in_ch();
    sntp7seg_out_if out_ch();

    sntp_time_line_to_seven_segment_core #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted display words, oldest first.
    t_display_word pending_words[$];

    // Shadow copy of the line buffer and display state.
    logic [7:0] line_mem [LINE_BYTES];
    int         line_len;
    int         digit_val [4];
    logic [3:0] point_bits;
    logic [1:0] scan_pos;

    int mismatches    = 0;
    int cycles        = 0;
    int words_sent    = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    bit steady        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            out_ch.ready <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left    <= SINK_HOLD_CYCLES;
        end else begin
            out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] seen);
        mismatches++;
        $display("MISMATCH at %0t: %s expected %0h, got %0h", $time, what, want, seen);
    endtask

    always @(posedge i_clk) begin : result_check
        t_display_word seen;
        t_display_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.echo_valid     = out_ch.echo_valid;
            seen.echo_byte      = out_ch.echo_byte;
            seen.time_updated   = out_ch.time_updated;
            seen.scan_valid     = out_ch.scan_valid;
            seen.digit_enable_n = out_ch.digit_enable_n;
            seen.segments       = out_ch.segments;
            seen.decimal_point  = out_ch.decimal_point;
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", 16'h0, 16'(seen));
            end else begin
                want = pending_words.pop_front();
                if (seen.echo_valid !== want.echo_valid)
                    report_mismatch("echo_valid", 16'(want.echo_valid),
                                    16'(seen.echo_valid));
                if (seen.echo_byte !== want.echo_byte)
                    report_mismatch("echo_byte", 16'(want.echo_byte), 16'(seen.echo_byte));
                if (seen.time_updated !== want.time_updated)
                    report_mismatch("time_updated", 16'(want.time_updated),
                                    16'(seen.time_updated));
                if (seen.scan_valid !== want.scan_valid)
                    report_mismatch("scan_valid", 16'(want.scan_valid),
                                    16'(seen.scan_valid));
                if (seen.digit_enable_n !== want.digit_enable_n)
                    report_mismatch("digit_enable_n", 16'(want.digit_enable_n),
                                    16'(seen.digit_enable_n));
                if (seen.segments !== want.segments)
                    report_mismatch("segments", 16'(want.segments), 16'(seen.segments));
                if (seen.decimal_point !== want.decimal_point)
                    report_mismatch("decimal_point", 16'(want.decimal_point),
                                    16'(seen.decimal_point));
            end
        end
    end

    // Characters past the end of the line read as zero; others are signed bytes.
    function automatic int char_code(input int p, input int len);
        if (p >= len || p >= LINE_BYTES) return 0;
        return int'($signed(line_mem[p]));
    endfunction

    function automatic bit parse_time_reply();
        int len;
        int at;
        int q;
        int c;
        int k;
        int hour;
        int minute;
        len = 0;
        while (len < line_len && len < LINE_BYTES && line_mem[len] != CHR_NUL) len++;
        at = -1;
        for (int p = 0; p + TAG_LENGTH <= len && at < 0; p++) begin
            k = 0;
            while (k < TAG_LENGTH && line_mem[p + k] == TAG_TEXT[k]) k++;
            if (k == TAG_LENGTH) at = p;
        end
        if (at < 0) return 1'b0;
        q = at + TAG_LENGTH;
        c = q;
        while (c < len && line_mem[c] != CHR_COLON) c++;
        if (c >= len || c < q + 2) return 1'b0;
        hour   = (char_code(c - 2, len) - 48) * 10 + (char_code(c - 1, len) - 48);
        minute = (char_code(c + 1, len) - 48) * 10 + (char_code(c + 2, len) - 48);
        if (hour < 0 || hour > MAX_HOUR || minute < 0 || minute > MAX_MINUTE) return 1'b0;
        digit_val[3] = hour / 10;
        digit_val[2] = hour % 10;
        digit_val[1] = minute / 10;
        digit_val[0] = minute % 10;
        point_bits   = HOUR_MINUTE_POINT;
        return 1'b1;
    endfunction

    function automatic t_display_word predict_display_word(input bit act,
                                                           input logic [7:0] b);
        t_display_word w;
        w = '0;
        if (act == ACT_BYTE) begin
            w.echo_valid     = 1'b1;
            w.echo_byte      = b;
            w.digit_enable_n = 4'hF;
            if (b == CHR_CR || b == CHR_LF) begin
                if (line_len > 0) w.time_updated = parse_time_reply();
                line_len = 0;
            end else if (line_len + 1 < LINE_BYTES) begin
                line_mem[line_len] = b;
                line_len++;
            end
        end else begin
            w.scan_valid     = 1'b1;
            w.digit_enable_n = ~(4'b0001 << scan_pos);
            w.segments       = (digit_val[scan_pos] < BLANK) ?
                               DIGIT_GLYPHS[digit_val[scan_pos]] : 7'h00;
            w.decimal_point  = point_bits[scan_pos];
            scan_pos         = scan_pos + 2'd1;
        end
        return w;
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input bit act, input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_words.push_back(predict_display_word(act, b));
        words_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(ACT_TICK, 8'($urandom_range(255)));
    endtask

    // Scan ticks may be slipped in between the bytes of a line.
    task automatic send_text(input string s, input bit with_ticks);
        for (int i = 0; i < s.len(); i++) begin
            if (with_ticks && $urandom_range(9) == 0) send_ticks(1);
            send_word(ACT_BYTE, s[i]);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    function automatic string random_junk(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(8'h20, 8'h7E)))};
        return s;
    endfunction

    task automatic test_blank_display();
        send_ticks(4);
        wait_drained();
    endtask

    task automatic test_time_replies();
        send_text("+CIPSNTPTIME:Thu Jan 01 00:00:00 1970", 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        send_word(ACT_BYTE, CHR_LF);
        send_ticks(4);
        send_text("+CIPSNTPTIME:Sun Dec 31 23:59:59 2023", 1'b0);
        send_word(ACT_BYTE, CHR_LF);
        send_ticks(4);
        // The minute's second digit lies past the end of the line and reads as a zero byte.
        send_text("+CIPSNTPTIME:12:5", 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        send_ticks(4);
        wait_drained();
    endtask

    task automatic test_rejected_replies();
        string bad_lines [6];
        bad_lines = '{"+CIPSNTPTIME:24:00", "+CIPSNTPTIME:12:60", "+CIPSNTPTIME:7:45",
                      "+CIPSNTPTIME:1234", "+CIPSNTPTIM:12:34", "+CIPSNTPTIME:09:"};
        foreach (bad_lines[i]) begin
            send_text(bad_lines[i], 1'b0);
            send_word(ACT_BYTE, CHR_LF);
        end
        // A byte with its top bit set gives a negative digit.
        send_text("+CIPSNTPTIME:1", 1'b0);
        send_word(ACT_BYTE, 8'hB4);
        send_text(":30", 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        // A zero byte cuts the line short of the time.
        send_text("+CIPSNTPTIME:", 1'b0);
        send_word(ACT_BYTE, CHR_NUL);
        send_text("11:22", 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        send_ticks(4);
        wait_drained();
    endtask

    task automatic test_line_overflow();
        string filler;
        filler = "";
        repeat (61) filler = {filler, "a"};
        // Fills the buffer exactly; the bytes after it are dropped.
        send_text({"+CIPSNTPTIME:", filler, "20:15", "999"}, 1'b0);
        send_word(ACT_BYTE, CHR_LF);
        send_ticks(4);
        // The time lies beyond the buffer, so the display keeps its value.
        send_text({filler, "aaaaaaaaaaaaaa", "+CIPSNTPTIME:01:02"}, 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        send_ticks(4);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int    stop_at;
        int    pick;
        int    pos;
        string s;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                s = $sformatf("%s+CIPSNTPTIME:%s %02d:%02d:%02d 2024",
                              random_junk($urandom_range(0, 6)),
                              random_junk($urandom_range(0, 12)),
                              $urandom_range(29), $urandom_range(69), $urandom_range(59));
                if ($urandom_range(7) == 0) begin
                    pos = $urandom_range(s.len() - 1);
                    s[pos] = 8'($urandom_range(128, 255));
                end
                send_text(s, 1'b1);
                if ($urandom_range(2) == 0) send_word(ACT_BYTE, CHR_CR);
                send_word(ACT_BYTE, $urandom_range(1) ? CHR_LF : CHR_CR);
            end else if (pick < 65) begin
                s = "+CIPSNTPTIME:";
                if ($urandom_range(1)) begin
                    s[$urandom_range(TAG_LENGTH - 1)] = 8'($urandom_range(8'h20, 8'h7E));
                    s = {s, $sformatf("%02d:%02d", $urandom_range(23), $urandom_range(59))};
                end else begin
                    s = {s.substr(0, $urandom_range(TAG_LENGTH - 1)),
                         random_junk($urandom_range(0, 5))};
                end
                send_text(s, 1'b1);
                send_word(ACT_BYTE, CHR_LF);
            end else if (pick < 80) begin
                send_ticks($urandom_range(1, 8));
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 24)) send_word(ACT_BYTE, 8'($urandom_range(255)));
                if ($urandom_range(1)) send_word(ACT_BYTE, CHR_LF);
            end else begin
                s = $sformatf("%s+CIPSNTPTIME:%02d:%02d%s", random_junk($urandom_range(40, 75)),
                              $urandom_range(23), $urandom_range(59),
                              random_junk($urandom_range(0, 20)));
                send_text(s, 1'b0);
                send_word(ACT_BYTE, CHR_CR);
            end
        end
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        test_random_traffic(300);
        steady = 1'b0;
        wait_drained();
    endtask

    // Keeps offering words while the output is held off, so the core backs up.
    task automatic test_output_hold();
        hold_requests <= hold_requests + 1;
        send_text("+CIPSNTPTIME:Mon Feb 02 08:41:00 2024", 1'b1);
        send_word(ACT_BYTE, CHR_LF);
        send_ticks(12);
        send_text("noise+CIPSNTPTIME:19:07", 1'b0);
        send_word(ACT_BYTE, CHR_CR);
        send_ticks(8);
        wait_drained();
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.action  = ACT_BYTE;
        in_ch.rx_byte = 8'h00;
        i_rst_n       = 1'b0;
        line_len      = 0;
        point_bits    = 4'h0;
        scan_pos      = 2'd0;
        foreach (digit_val[i]) digit_val[i] = BLANK;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blank_display();
        test_time_replies();
        test_rejected_replies();
        test_line_overflow();
        test_random_traffic(600);
        test_steady_stream();
        test_output_hold();
        test_random_traffic(250);

        wait_drained();
        repeat (LINE_BYTES + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
